/* rtl/rlbc_pkg.sv */
// Package with the constants, codes and state type of the LRU block cache controller.
package rlbc_pkg;
	localparam int NUM_ENTRIES = 16;
	localparam int IDX_W = $clog2(NUM_ENTRIES);
	localparam int SLOT_W = 5;
	localparam int TAG_W = 16;
	localparam int PIN_W = 8;
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_MARK = 2'd2;
	localparam logic [1:0] OP_SYNC = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_CACHED = 2'd1;
	localparam logic [1:0] ST_NO_FREE = 2'd2;
	localparam logic [1:0] ST_PIN_ERR = 2'd3;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_FLUSH = 2'd3;

	localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_HIT,
		S_MISS,
		S_EVICT,
		S_FILL,
		S_FLUSH
	} state_t;
endpackage

/* rtl/refcounted_lru_block_cache_unit.sv */
// Top level of the reference-counted LRU block cache controller.
//
//  channel   signals                                    handshake
//  request   op, block_number, dirty_flag               start in, busy out
//  result    status, hit, slot, device_command,         strobe out, one cycle
//            device_block, last
//
// An item is accepted when start is high and busy is low; busy then stays high until it is done.
// A hit ends the tag scan at its slot. A miss scans all 16 entries, then decides; an acquire
// then writes back a dirty victim if there is one and issues the read. Sync, an uncached block
// and a full pool also scan all 16 entries.
// Results are registered, one per cycle at most, and busy is already low while the final
// result of an item is shown; the receiver cannot stall. Reset leaves every entry free in order.
module refcounted_lru_block_cache_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [rlbc_pkg::TAG_W-1:0]   block_number,
	input  logic                         dirty_flag,
	output logic                         strobe,
	output logic [1:0]                   status,
	output logic                         hit,
	output logic [rlbc_pkg::SLOT_W-1:0]  slot,
	output logic [1:0]                   device_command,
	output logic [rlbc_pkg::TAG_W-1:0]   device_block,
	output logic                         last
);
	import rlbc_pkg::*;

	state_t state_q, state_d;

	logic [TAG_W-1:0] tag_mem [NUM_ENTRIES];
	logic [TAG_W-1:0] rd_data;
	logic [IDX_W-1:0] rd_addr;
	logic             tag_we;

	logic [NUM_ENTRIES-1:0] valid_q, dirty_q;
	logic [PIN_W-1:0]       pins_q [NUM_ENTRIES];
	logic [SLOT_W-1:0]      next_q [NUM_ENTRIES];
	logic [SLOT_W-1:0]      prev_q [NUM_ENTRIES];
	logic [SLOT_W-1:0]      head_q, tail_q;
	logic [CNT_W-1:0]       free_q;

	logic [1:0]       op_q;
	logic [TAG_W-1:0] blk_q;
	logic             dflag_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] slot_q;

	logic             issue, scan_end, match, sync_wr;
	logic [PIN_W-1:0] pin_cur;

	logic             res_v;
	logic [1:0]       res_st, res_cmd;
	logic             res_hit, res_last;
	logic [SLOT_W-1:0] res_slot;
	logic [TAG_W-1:0] res_blk;

	logic             do_unlink, do_append, pin_inc, pin_dec, set_dirty, fill;
	logic [IDX_W-1:0] ul_slot;
	logic [IDX_W-1:0] ul_p, ul_n;

	assign busy = (state_q != S_IDLE);
	assign issue = (state_q == S_SEARCH) && (idx_q != CNT_W'(NUM_ENTRIES));
	assign scan_end = vld_s1 && (idx_s1 == IDX_W'(NUM_ENTRIES - 1));
	assign match = vld_s1 && valid_q[idx_s1] && (rd_data == blk_q);
	assign sync_wr = vld_s1 && valid_q[idx_s1] && dirty_q[idx_s1];
	assign pin_cur = pins_q[slot_q];
	assign ul_p = prev_q[ul_slot][IDX_W-1:0];
	assign ul_n = next_q[ul_slot][IDX_W-1:0];

	always_comb begin
		rd_addr = '0;
		if (state_q == S_SEARCH) begin
			rd_addr = idx_q[IDX_W-1:0];
		end else if (state_q == S_MISS) begin
			rd_addr = head_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= tag_mem[rd_addr];
		if (tag_we) begin
			tag_mem[slot_q] <= blk_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (op_q != OP_SYNC && match) begin
					state_d = S_HIT;
				end else if (scan_end) begin
					state_d = (op_q == OP_SYNC) ? S_FLUSH : S_MISS;
				end
			end
			S_MISS: begin
				if (op_q == OP_ACQUIRE && free_q != '0) begin
					state_d = (valid_q[head_q[IDX_W-1:0]] && dirty_q[head_q[IDX_W-1:0]])
						? S_EVICT : S_FILL;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EVICT: state_d = S_FILL;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		res_v = 1'b0;
		res_st = ST_OK;
		res_hit = 1'b0;
		res_slot = '0;
		res_cmd = CMD_NONE;
		res_blk = '0;
		res_last = 1'b1;
		do_unlink = 1'b0;
		do_append = 1'b0;
		pin_inc = 1'b0;
		pin_dec = 1'b0;
		set_dirty = 1'b0;
		fill = 1'b0;
		tag_we = 1'b0;
		ul_slot = slot_q;
		case (state_q)
			S_SEARCH: begin
				if (op_q == OP_SYNC && sync_wr) begin
					res_v = 1'b1;
					res_slot = SLOT_W'(idx_s1);
					res_cmd = CMD_WRITE;
					res_blk = rd_data;
					res_last = 1'b0;
				end
			end
			S_HIT: begin
				res_v = 1'b1;
				res_slot = SLOT_W'(slot_q);
				case (op_q)
					OP_ACQUIRE: begin
						res_hit = 1'b1;
						if (pin_cur == PIN_MAX) begin
							res_st = ST_PIN_ERR;
						end else begin
							pin_inc = 1'b1;
							do_unlink = (pin_cur == '0);
						end
					end
					OP_MARK: set_dirty = 1'b1;
					default: begin
						if (pin_cur == '0) begin
							res_st = ST_PIN_ERR;
						end else begin
							set_dirty = dflag_q;
							pin_dec = 1'b1;
							do_append = (pin_cur == PIN_W'(1));
						end
					end
				endcase
			end
			S_MISS: begin
				ul_slot = head_q[IDX_W-1:0];
				if (op_q != OP_ACQUIRE) begin
					res_v = 1'b1;
					res_st = ST_NOT_CACHED;
				end else if (free_q == '0) begin
					res_v = 1'b1;
					res_st = ST_NO_FREE;
				end else begin
					do_unlink = 1'b1;
				end
			end
			S_EVICT: begin
				res_v = 1'b1;
				res_slot = SLOT_W'(slot_q);
				res_cmd = CMD_WRITE;
				res_blk = rd_data;
				res_last = 1'b0;
			end
			S_FILL: begin
				res_v = 1'b1;
				res_slot = SLOT_W'(slot_q);
				res_cmd = CMD_READ;
				res_blk = blk_q;
				fill = 1'b1;
				tag_we = 1'b1;
			end
			S_FLUSH: begin
				res_v = 1'b1;
				res_cmd = CMD_FLUSH;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1 <= 1'b0;
			strobe <= 1'b0;
			valid_q <= '0;
			dirty_q <= '0;
			head_q <= '0;
			tail_q <= SLOT_W'(NUM_ENTRIES - 1);
			free_q <= CNT_W'(NUM_ENTRIES);
			idx_q <= '0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				pins_q[i] <= '0;
				next_q[i] <= SLOT_W'(i + 1);
				prev_q[i] <= SLOT_W'(i - 1);
			end
		end else begin
			state_q <= state_d;
			vld_s1 <= issue && (state_d == S_SEARCH);
			strobe <= res_v;
			if (state_q == S_IDLE && start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (state_q == S_SEARCH && op_q == OP_SYNC && sync_wr) begin
				dirty_q[idx_s1] <= 1'b0;
			end
			if (set_dirty) dirty_q[slot_q] <= 1'b1;
			if (pin_inc) pins_q[slot_q] <= pin_cur + PIN_W'(1);
			if (pin_dec) pins_q[slot_q] <= pin_cur - PIN_W'(1);
			if (fill) begin
				valid_q[slot_q] <= 1'b1;
				dirty_q[slot_q] <= 1'b0;
				pins_q[slot_q] <= PIN_W'(1);
			end
			if (do_unlink && free_q != '0) begin
				free_q <= free_q - CNT_W'(1);
				if (free_q != CNT_W'(1)) begin
					if (SLOT_W'(ul_slot) == head_q) begin
						head_q <= next_q[ul_slot];
					end else if (SLOT_W'(ul_slot) == tail_q) begin
						tail_q <= prev_q[ul_slot];
					end else begin
						next_q[ul_p] <= next_q[ul_slot];
						prev_q[ul_n] <= prev_q[ul_slot];
					end
				end
			end
			if (do_append) begin
				free_q <= free_q + CNT_W'(1);
				tail_q <= SLOT_W'(slot_q);
				if (free_q == '0) begin
					head_q <= SLOT_W'(slot_q);
				end else begin
					next_q[tail_q[IDX_W-1:0]] <= SLOT_W'(slot_q);
					prev_q[slot_q] <= tail_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= op;
			blk_q <= block_number;
			dflag_q <= dirty_flag;
		end
		idx_s1 <= idx_q[IDX_W-1:0];
		if (state_q == S_SEARCH && match) begin
			slot_q <= idx_s1;
		end else if (state_q == S_MISS) begin
			slot_q <= head_q[IDX_W-1:0];
		end
		status <= res_st;
		hit <= res_hit;
		slot <= res_slot;
		device_command <= res_cmd;
		device_block <= res_blk;
		last <= res_last;
	end
endmodule

/* rtl/rlbc_checker.sv */
// Port-level checker for the block cache controller and its bind statement.
module rlbc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         strobe,
	input logic [1:0]                   status,
	input logic [rlbc_pkg::SLOT_W-1:0]  slot,
	input logic [1:0]                   device_command,
	input logic                         last
);
	import rlbc_pkg::*;

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy) else $error("final result while busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy) else $error("partial result while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	a_flush_form: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && device_command == CMD_FLUSH |-> last && slot == '0 && status == ST_OK)
		else $error("malformed flush result");
endmodule

bind refcounted_lru_block_cache_unit rlbc_checker u_rlbc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.strobe(strobe),
	.status(status),
	.slot(slot),
	.device_command(device_command),
	.last(last)
);

/* tb/sv/tb_refcounted_lru_block_cache_unit.sv */
// Self-checking testbench for the reference-counted LRU block cache controller.
module tb_refcounted_lru_block_cache_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rlbc_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic hit;
		logic [SLOT_W-1:0] slot;
		logic [1:0] cmd;
		logic [TAG_W-1:0] blk;
		logic last;
	} cache_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = OP_ACQUIRE;
	logic [TAG_W-1:0] block_number = '0;
	logic dirty_flag = 1'b0;
	logic busy, strobe, hit, last;
	logic [1:0] status, device_command;
	logic [SLOT_W-1:0] slot;
	logic [TAG_W-1:0] device_block;

	logic [TAG_W-1:0] tag_mem [NUM_ENTRIES];
	logic valid_mem [NUM_ENTRIES];
	logic dirty_mem [NUM_ENTRIES];
	logic [PIN_W-1:0] pin_mem [NUM_ENTRIES];
	logic [SLOT_W-1:0] lru_next [32];
	logic [SLOT_W-1:0] lru_prev [32];
	logic [SLOT_W-1:0] lru_head, lru_tail;
	int free_entries;

	cache_result_t pending_results [$];
	int errors = 0;
	logic busy_seen = 1'b1;

	refcounted_lru_block_cache_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.block_number(block_number), .dirty_flag(dirty_flag), .strobe(strobe),
		.status(status), .hit(hit), .slot(slot), .device_command(device_command),
		.device_block(device_block), .last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("refcounted_lru_block_cache_unit test failed");
		$finish;
	end

	function automatic int lookup(input logic [TAG_W-1:0] blk);
		for (int i = 0; i < NUM_ENTRIES; i++)
			if (valid_mem[i] && tag_mem[i] == blk)
				return i;
		return -1;
	endfunction

	function automatic void unlink_entry(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] p, n;
		if (free_entries == 0)
			return;
		if (free_entries == 1) begin
			free_entries = 0;
			return;
		end
		p = lru_prev[s];
		n = lru_next[s];
		if (s == lru_head) begin
			lru_head = n;
		end else if (s == lru_tail) begin
			lru_tail = p;
		end else begin
			lru_next[p] = n;
			lru_prev[n] = p;
		end
		free_entries--;
	endfunction

	function automatic void append_entry(input logic [SLOT_W-1:0] s);
		if (free_entries == 0) begin
			lru_head = s;
			lru_tail = s;
		end else begin
			lru_next[lru_tail] = s;
			lru_prev[s] = lru_tail;
			lru_tail = s;
		end
		free_entries++;
	endfunction

	function automatic void expect_result(input logic [1:0] st, input logic h,
			input int s, input logic [1:0] cmd, input logic [TAG_W-1:0] blk,
			input logic lst);
		cache_result_t r;
		r.status = st;
		r.hit = h;
		r.slot = SLOT_W'(s);
		r.cmd = cmd;
		r.blk = blk;
		r.last = lst;
		pending_results = {pending_results, r};
	endfunction

	function automatic void predict_request(input logic [1:0] o,
			input logic [TAG_W-1:0] blk, input logic df);
		int s;
		s = lookup(blk);
		case (o)
			OP_ACQUIRE: begin
				if (s >= 0) begin
					if (pin_mem[s] == PIN_MAX) begin
						expect_result(ST_PIN_ERR, 1'b1, s, CMD_NONE, '0, 1'b1);
					end else begin
						if (pin_mem[s] == 0)
							unlink_entry(SLOT_W'(s));
						pin_mem[s]++;
						expect_result(ST_OK, 1'b1, s, CMD_NONE, '0, 1'b1);
					end
				end else if (free_entries == 0) begin
					expect_result(ST_NO_FREE, 1'b0, 0, CMD_NONE, '0, 1'b1);
				end else begin
					s = lru_head;
					unlink_entry(SLOT_W'(s));
					if (valid_mem[s] && dirty_mem[s])
						expect_result(ST_OK, 1'b0, s, CMD_WRITE, tag_mem[s], 1'b0);
					tag_mem[s] = blk;
					valid_mem[s] = 1'b1;
					dirty_mem[s] = 1'b0;
					pin_mem[s] = 1;
					expect_result(ST_OK, 1'b0, s, CMD_READ, blk, 1'b1);
				end
			end
			OP_RELEASE, OP_MARK: begin
				if (s < 0) begin
					expect_result(ST_NOT_CACHED, 1'b0, 0, CMD_NONE, '0, 1'b1);
				end else if (o == OP_MARK) begin
					dirty_mem[s] = 1'b1;
					expect_result(ST_OK, 1'b0, s, CMD_NONE, '0, 1'b1);
				end else if (pin_mem[s] == 0) begin
					expect_result(ST_PIN_ERR, 1'b0, s, CMD_NONE, '0, 1'b1);
				end else begin
					if (df)
						dirty_mem[s] = 1'b1;
					pin_mem[s]--;
					if (pin_mem[s] == 0)
						append_entry(SLOT_W'(s));
					expect_result(ST_OK, 1'b0, s, CMD_NONE, '0, 1'b1);
				end
			end
			default: begin
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (valid_mem[i] && dirty_mem[i]) begin
						expect_result(ST_OK, 1'b0, i, CMD_WRITE, tag_mem[i], 1'b0);
						dirty_mem[i] = 1'b0;
					end
				end
				expect_result(ST_OK, 1'b0, 0, CMD_FLUSH, '0, 1'b1);
			end
		endcase
	endfunction

	always @(negedge clk)
		busy_seen <= busy;

	always @(negedge clk) begin
		cache_result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d slot %0d", status, slot);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					errors++;
				end
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					errors++;
				end
				if (device_command !== want.cmd) begin
					$error("device_command: expected %0d, got %0d", want.cmd,
						device_command);
					errors++;
				end
				if (device_block !== want.blk) begin
					$error("device_block: expected %0d, got %0d", want.blk, device_block);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					errors++;
				end
			end
		end
	end

	task automatic send_request(input logic [1:0] o, input logic [TAG_W-1:0] blk,
			input logic df = 1'b0);
		int gap;
		gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		block_number <= blk;
		dirty_flag <= df;
		forever begin
			@(posedge clk);
			if (!busy_seen)
				break;
		end
		predict_request(o, blk, df);
	endtask

	task automatic test_basic_ops();
		send_request(OP_ACQUIRE, 16'h0000);
		send_request(OP_ACQUIRE, 16'hFFFF);
		send_request(OP_ACQUIRE, 16'h0000);
		send_request(OP_RELEASE, 16'h0000, 1'b1);
		send_request(OP_RELEASE, 16'h0000, 1'b0);
		send_request(OP_RELEASE, 16'h0000, 1'b1);
		send_request(OP_RELEASE, 16'hFFFF, 1'b0);
		send_request(OP_MARK, 16'hFFFF);
		send_request(OP_MARK, 16'h5AA5);
		send_request(OP_RELEASE, 16'hA55A, 1'b1);
		send_request(OP_SYNC, 16'h0000);
		send_request(OP_SYNC, 16'hFFFF, 1'b1);
	endtask

	task automatic test_full_pool();
		for (int i = 0; i < NUM_ENTRIES; i++)
			send_request(OP_ACQUIRE, 16'(100 + i));
		send_request(OP_ACQUIRE, 16'd200);
		for (int i = 0; i < NUM_ENTRIES; i++)
			send_request(OP_RELEASE, 16'(100 + i), 1'(i));
		send_request(OP_ACQUIRE, 16'd201);
		send_request(OP_ACQUIRE, 16'd202);
		send_request(OP_RELEASE, 16'd201, 1'b1);
		send_request(OP_RELEASE, 16'd202, 1'b0);
		send_request(OP_SYNC, 16'd0);
	endtask

	task automatic test_pin_limit();
		for (int i = 0; i < 20; i++)
			send_request(OP_ACQUIRE, 16'h8001);
		send_request(OP_MARK, 16'h8001);
		for (int i = 0; i < 21; i++)
			send_request(OP_RELEASE, 16'h8001, 1'b0);
	endtask

	task automatic test_random_traffic();
		logic [TAG_W-1:0] base, blk;
		int pick, s;
		base = 16'($urandom);
		for (int n = 0; n < 140; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				blk = 16'($urandom);
			else
				blk = base + 16'($urandom_range(0, 23));
			if (pick < 40) begin
				send_request(OP_ACQUIRE, blk);
			end else if (pick < 80) begin
				if ($urandom_range(0, 4) != 0) begin
					s = $urandom_range(0, NUM_ENTRIES - 1);
					for (int k = 0; k < NUM_ENTRIES; k++) begin
						if (valid_mem[(s + k) % NUM_ENTRIES] &&
								pin_mem[(s + k) % NUM_ENTRIES] != 0) begin
							blk = tag_mem[(s + k) % NUM_ENTRIES];
							break;
						end
					end
				end
				send_request(OP_RELEASE, blk, 1'($urandom));
			end else if (pick < 92) begin
				send_request(OP_MARK, blk);
			end else begin
				send_request(OP_SYNC, 16'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 32; i++) begin
			lru_next[i] = SLOT_W'(i + 1);
			lru_prev[i] = SLOT_W'(i + 31);
		end
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			tag_mem[i] = '0;
			valid_mem[i] = 1'b0;
			dirty_mem[i] = 1'b0;
			pin_mem[i] = '0;
		end
		lru_head = '0;
		lru_tail = SLOT_W'(NUM_ENTRIES - 1);
		free_entries = NUM_ENTRIES;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_full_pool();
		test_pin_limit();
		test_random_traffic();
		start <= 1'b0;
		for (int w = 0; w < 5000 && pending_results.size() != 0; w++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("refcounted_lru_block_cache_unit test passed");
		end else begin
			if (pending_results.size() != 0)
				$error("%0d expected results never arrived", pending_results.size());
			$display("refcounted_lru_block_cache_unit test failed");
		end
		$finish;
	end
endmodule
